[src/scim_pkg.sv]
// Shared types, constants and decode functions for the system controller
// interrupt mask block. No dependencies; every other file in src uses it.
package scim_pkg;

    localparam int MASK_SETS    = 2;   // mask sets held (1 to 4)
    localparam int SETS_USABLE  = 2;   // sets A and B only can be enabled
    localparam int WORD_W       = 36;
    localparam int MASK_W       = 32;
    localparam int ASSIGN_W     = 9;
    localparam int PORTS        = 8;
    localparam int PORT_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    typedef enum logic [2:0] {
        MODE_SET_MASK    = 3'd0,
        MODE_GET_MASK    = 3'd1,
        MODE_MODE_REG    = 3'd2,
        MODE_READ_SWITCH = 3'd3,
        MODE_WRITE_SWITCH= 3'd4,
        MODE_RAISE       = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_MASK  = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECEIVING_PORT = 2'd0,
        CFG_MANUAL_MODE    = 2'd1,
        CFG_CPU_PORT_MAP   = 2'd2,
        CFG_SETS_PRESENT   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PORT_W-1:0] receiving_port;
        logic              manual_mode;
        logic [PORTS-1:0]  cpu_port_map;
        logic [1:0]        mask_sets_present;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [PORT_W-1:0] target_port;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_q;
        logic [4:0]        interrupt_number;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_a;
        logic [WORD_W-1:0] result_q;
        logic [1:0]        status;
        logic              interrupt_delivered;
        logic [MASK_W-1:0] pending_vector;
    } res_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              off;
    } assign_dec_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] q;
    } word_pair_t;

    // highest port number (lowest set port bit) wins; port kept when no port bit set
    function automatic assign_dec_t assign_decode(input logic [ASSIGN_W-1:0] raw,
                                                  input logic [PORT_W-1:0]   old_port);
        assign_dec_t d;
        d.port = old_port;
        for (int p = 0; p < PORTS; p++)
        begin
            if (raw[ASSIGN_W-1-p])
            begin
                d.port = PORT_W'(p);
            end
        end
        d.off = raw[0] | ~(|raw[ASSIGN_W-1:1]);
        return d;
    endfunction

    // enables of four ports, first port in the most significant bit
    function automatic logic [3:0] enables_nibble(input logic [PORTS-1:0] pe,
                                                  input logic             upper);
        logic [3:0] n;
        for (int i = 0; i < 4; i++)
        begin
            n[3-i] = upper ? pe[4+i] : pe[i];
        end
        return n;
    endfunction

    function automatic word_pair_t switches_word(input logic [ASSIGN_W-1:0] raw0,
                                                 input logic [ASSIGN_W-1:0] raw1,
                                                 input logic [PORT_W-1:0]   rport,
                                                 input logic                manual,
                                                 input logic [PORTS-1:0]    pe);
        word_pair_t w;
        w.a        = '0;
        w.q        = '0;
        w.a[35:27] = raw0;
        w.a[26:24] = 3'd5;
        w.a[23:20] = 4'hF;
        w.a[19:16] = {1'b0, rport};
        w.a[14]    = manual;
        w.a[5]     = 1'b1;
        w.a[3:0]   = enables_nibble(pe, 1'b0);
        w.q[35:27] = raw1;
        w.q[3:0]   = enables_nibble(pe, 1'b1);
        return w;
    endfunction

endpackage

[src/scim_cfg_regs.sv]
// Configuration registers of the interrupt mask block, written through a
// plain write port. Depends on scim_pkg.
module scim_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scim_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scim_pkg::CFG_DATA_W-1:0]  cfg_data,
    output scim_pkg::cfg_t                   cfg
);

    scim_pkg::cfg_t cfg_reg;
    scim_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scim_pkg::CFG_RECEIVING_PORT: cfg_next.receiving_port    = cfg_data[2:0];
                scim_pkg::CFG_MANUAL_MODE:    cfg_next.manual_mode       = cfg_data[0];
                scim_pkg::CFG_CPU_PORT_MAP:   cfg_next.cpu_port_map      = cfg_data[7:0];
                scim_pkg::CFG_SETS_PRESENT:   cfg_next.mask_sets_present = cfg_data[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.receiving_port    <= '0;
            cfg_reg.manual_mode       <= 1'b1;
            cfg_reg.cpu_port_map      <= '0;
            cfg_reg.mask_sets_present <= 2'b11;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/scim_core.sv]
// Mask sets, port enables and pending vector, with the single-pass logic
// that executes one request and forms its result. Depends on scim_pkg.
module scim_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  scim_pkg::req_t   req,
    input  scim_pkg::cfg_t   cfg,
    output scim_pkg::res_t   res
);

    localparam int NS = scim_pkg::MASK_SETS;

    logic [scim_pkg::MASK_W-1:0]   exec_mask_reg   [NS];
    logic [scim_pkg::MASK_W-1:0]   exec_mask_next  [NS];
    logic [scim_pkg::ASSIGN_W-1:0] assign_word_reg [NS];
    logic [scim_pkg::ASSIGN_W-1:0] assign_word_next[NS];
    logic [scim_pkg::PORT_W-1:0]   assign_port_reg [NS];
    logic [scim_pkg::PORT_W-1:0]   assign_port_next[NS];
    logic                          assign_off_reg  [NS];
    logic                          assign_off_next [NS];
    logic [scim_pkg::PORTS-1:0]    port_enable_reg;
    logic [scim_pkg::PORTS-1:0]    port_enable_next;
    logic [scim_pkg::MASK_W-1:0]   pending_reg;
    logic [scim_pkg::MASK_W-1:0]   pending_next;

    logic [NS-1:0]                 usable;
    logic [NS-1:0]                 match_t;
    logic [NS-1:0]                 match_r;
    logic [NS-1:0]                 hit;
    logic [NS-1:0]                 deliver;
    logic [scim_pkg::MASK_W-1:0]   hit_mask;
    logic [scim_pkg::ASSIGN_W-1:0] raw_cur [2];
    logic [scim_pkg::ASSIGN_W-1:0] raw_new [2];
    logic [scim_pkg::PORTS-1:0]    pe_new;
    scim_pkg::word_pair_t          sw_cur;
    scim_pkg::word_pair_t          sw_new;
    scim_pkg::assign_dec_t         dec;

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_set
            if (g < scim_pkg::SETS_USABLE)
            begin : g_use
                assign usable[g] = cfg.mask_sets_present[g] & ~assign_off_reg[g];
            end
            else
            begin : g_nouse
                assign usable[g] = 1'b0;
            end
            assign match_t[g] = usable[g] & (assign_port_reg[g] == req.target_port);
            assign match_r[g] = usable[g] & (assign_port_reg[g] == cfg.receiving_port);
            assign deliver[g] = usable[g] & exec_mask_reg[g][req.interrupt_number]
                                & cfg.cpu_port_map[assign_port_reg[g]];
        end
        for (g = 0; g < 2; g++)
        begin : g_raw
            if (g < NS)
            begin : g_held
                assign raw_cur[g] = assign_word_reg[g];
            end
            else
            begin : g_absent
                assign raw_cur[g] = scim_pkg::ASSIGN_W'(1);
            end
        end
    endgenerate

    // last matching set wins
    always_comb
    begin
        logic taken;
        taken    = 1'b0;
        hit      = '0;
        hit_mask = '0;
        for (int s = NS - 1; s >= 0; s--)
        begin
            if (match_t[s] && !taken)
            begin
                hit[s]   = 1'b1;
                hit_mask = exec_mask_reg[s];
                taken    = 1'b1;
            end
        end
    end

    always_comb
    begin
        raw_new[0] = req.word_a[35:27];
        raw_new[1] = (NS > 1) ? req.word_q[35:27] : scim_pkg::ASSIGN_W'(1);
        for (int i = 0; i < 4; i++)
        begin
            pe_new[i]   = req.word_a[3-i];
            pe_new[4+i] = req.word_q[3-i];
        end
    end

    assign sw_cur = scim_pkg::switches_word(raw_cur[0], raw_cur[1], cfg.receiving_port,
                                            cfg.manual_mode, port_enable_reg);
    assign sw_new = scim_pkg::switches_word(raw_new[0], raw_new[1], cfg.receiving_port,
                                            cfg.manual_mode, pe_new);

    always_comb
    begin
        exec_mask_next   = exec_mask_reg;
        assign_word_next = assign_word_reg;
        assign_port_next = assign_port_reg;
        assign_off_next  = assign_off_reg;
        port_enable_next = port_enable_reg;
        pending_next     = pending_reg;
        dec              = '0;
        res              = '0;

        case (req.mode)
            scim_pkg::MODE_SET_MASK:
            begin
                if (!(|match_r))
                begin
                    res.status = scim_pkg::STATUS_NO_MASK;
                end
                else
                begin
                    for (int s = 0; s < NS; s++)
                    begin
                        if (hit[s])
                        begin
                            exec_mask_next[s] = {req.word_a[35:20], req.word_q[35:20]};
                        end
                    end
                end
            end
            scim_pkg::MODE_GET_MASK:
            begin
                if (|hit)
                begin
                    res.result_a[35:20] = hit_mask[31:16];
                    res.result_a[3:0]   = scim_pkg::enables_nibble(port_enable_reg, 1'b0);
                    res.result_q[35:20] = hit_mask[15:0];
                    res.result_q[3:0]   = scim_pkg::enables_nibble(port_enable_reg, 1'b1);
                end
            end
            scim_pkg::MODE_MODE_REG:
            begin
                res.result_q[19] = 1'b1;
            end
            scim_pkg::MODE_READ_SWITCH:
            begin
                res.result_a = sw_cur.a;
                res.result_q = sw_cur.q;
            end
            scim_pkg::MODE_WRITE_SWITCH:
            begin
                for (int s = 0; s < NS; s++)
                begin
                    if (s < 2)
                    begin
                        dec                 = scim_pkg::assign_decode(raw_new[s],
                                                                      assign_port_reg[s]);
                        assign_word_next[s] = raw_new[s];
                        assign_port_next[s] = dec.port;
                        assign_off_next[s]  = dec.off;
                    end
                end
                port_enable_next = pe_new;
                if (sw_new.a != req.word_a || sw_new.q != req.word_q)
                begin
                    res.status = scim_pkg::STATUS_MISMATCH;
                end
                res.result_a = req.word_a;
                res.result_q = req.word_q;
            end
            scim_pkg::MODE_RAISE:
            begin
                if (|deliver)
                begin
                    pending_next = pending_reg
                                   | (scim_pkg::MASK_W'(1) << req.interrupt_number);
                    res.interrupt_delivered = 1'b1;
                end
            end
            default:
            begin
                res.status = scim_pkg::STATUS_OK;
            end
        endcase

        res.pending_vector = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                exec_mask_reg[s]   <= '0;
                assign_word_reg[s] <= scim_pkg::ASSIGN_W'(1);
                assign_port_reg[s] <= '0;
                assign_off_reg[s]  <= 1'b1;
            end
            port_enable_reg <= '0;
            pending_reg     <= '0;
        end
        else if (fire)
        begin
            exec_mask_reg   <= exec_mask_next;
            assign_word_reg <= assign_word_next;
            assign_port_reg <= assign_port_next;
            assign_off_reg  <= assign_off_next;
            port_enable_reg <= port_enable_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

[src/system_controller_interrupt_masks_unit.sv]
// Top level of the system controller interrupt mask block: request and
// result registers around scim_core, plus scim_cfg_regs. Depends on scim_pkg.
//
// Usage
//   Request channel: in_valid/in_stall with mode, target_port, word_a,
//   word_q and interrupt_number. A transfer happens on a rising edge with
//   in_valid high and in_stall low.
//   Result channel: out_valid/out_stall with result_a, result_q, status,
//   interrupt_delivered and pending_vector; one result per request, in order.
//   Configuration: cfg_we/cfg_index/cfg_data, one register per edge, to be
//   taken only while no request is in flight; the block does not enforce it.
//   Data path: the request register feeds one pass of mask-set logic that
//   writes the result register and the state; one request per cycle unless
//   a stalled, full result register holds the request register.
//   Stall: with out_stall high the result holds, the request register keeps
//   its item and in_stall rises once that register is also full.
//   Reset: rst_n (asynchronous, active low) empties both registers, clears
//   masks, enables and pending bits, marks both sets unassigned and loads
//   the configuration defaults (port 0, manual mode, no processors, both
//   sets present).
module system_controller_interrupt_masks_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       mode,
    input  logic [2:0]                       target_port,
    input  logic [35:0]                      word_a,
    input  logic [35:0]                      word_q,
    input  logic [4:0]                       interrupt_number,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [35:0]                      result_a,
    output logic [35:0]                      result_q,
    output logic [1:0]                       status,
    output logic                             interrupt_delivered,
    output logic [31:0]                      pending_vector,
    input  logic                             cfg_we,
    input  logic [scim_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scim_pkg::CFG_DATA_W-1:0]  cfg_data
);

    scim_pkg::cfg_t cfg;
    scim_pkg::req_t req_reg;
    scim_pkg::res_t res;
    scim_pkg::res_t res_reg;
    logic           req_valid_reg;
    logic           req_valid_next;
    logic           res_valid_reg;
    logic           res_valid_next;
    logic           advance;
    logic           accept;

    assign advance  = req_valid_reg & (~res_valid_reg | ~out_stall);
    assign in_stall = req_valid_reg & ~advance;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg & out_stall;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.mode             <= mode;
            req_reg.target_port      <= target_port;
            req_reg.word_a           <= word_a;
            req_reg.word_q           <= word_q;
            req_reg.interrupt_number <= interrupt_number;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    scim_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scim_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out_valid           = res_valid_reg;
    assign result_a            = res_reg.result_a;
    assign result_q            = res_reg.result_q;
    assign status              = res_reg.status;
    assign interrupt_delivered = res_reg.interrupt_delivered;
    assign pending_vector      = res_reg.pending_vector;

endmodule

[verif/tb.sv]
// Self-checking bench for system_controller_interrupt_masks_unit: a directed table,
// then random phases with mask-set state tracked alongside the block.
// Depends on scim_pkg and the RTL under src only.
module tb;
    import scim_pkg::*;

    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;
    localparam logic [35:0] ALL36        = {36{1'b1}};
    localparam int          RANDOM_ITEMS = 1750;

    typedef struct {
        bit         is_cfg;
        cfg_index_t cfg_reg;
        logic [7:0] cfg_val;
        req_t       req;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [2:0]            mode = '0;
    logic [2:0]            target_port = '0;
    logic [35:0]           word_a = '0;
    logic [35:0]           word_q = '0;
    logic [4:0]            interrupt_number = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [35:0]           result_a;
    logic [35:0]           result_q;
    logic [1:0]            status;
    logic                  interrupt_delivered;
    logic [31:0]           pending_vector;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // mirrored block state
    logic [31:0] sc_exec_mask   [MASK_SETS] = '{default: 32'd0};
    logic [8:0]  sc_assign_word [MASK_SETS] = '{default: 9'd1};
    logic [2:0]  sc_assign_port [MASK_SETS] = '{default: 3'd0};
    logic        sc_assign_off  [MASK_SETS] = '{default: 1'b1};
    logic [7:0]  sc_port_enable = 8'd0;
    logic [31:0] sc_pending     = 32'd0;
    logic [2:0]  cf_rport       = 3'd0;
    logic        cf_manual      = 1'b1;
    logic [7:0]  cf_cpu_map     = 8'd0;
    logic [1:0]  cf_present     = 2'd3;

    res_t        owed_replies [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          stall_hold = 0;
    bit          quiet = 1'b0;

    system_controller_interrupt_masks_unit dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .mode                (mode),
        .target_port         (target_port),
        .word_a              (word_a),
        .word_q              (word_q),
        .interrupt_number    (interrupt_number),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .result_a            (result_a),
        .result_q            (result_q),
        .status              (status),
        .interrupt_delivered (interrupt_delivered),
        .pending_vector      (pending_vector),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [35:0] rand36();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[35:0];
    endfunction

    function automatic bit set_live(int s);
        return (s < SETS_USABLE) && (s < MASK_SETS) && cf_present[s] && !sc_assign_off[s];
    endfunction

    function automatic logic [8:0] assign_raw(int s);
        return (s < MASK_SETS) ? sc_assign_word[s] : 9'd1;
    endfunction

    function automatic void load_assign(int s, logic [8:0] raw);
        int found = 0;
        if (s >= MASK_SETS)
            return;
        sc_assign_word[s] = raw;
        if (raw[0])
            sc_assign_off[s] = 1'b1;
        for (int p = 0; p < 8; p++)
        begin
            if (raw[8-p])
            begin
                found++;
                sc_assign_port[s] = 3'(p);
            end
        end
        if (!raw[0])
            sc_assign_off[s] = (found == 0);
    endfunction

    // config switches layout; the first port of each nibble (0 or 4) sits in bit 3
    function automatic void switch_layout(input logic [8:0] raw0, input logic [8:0] raw1,
                                          input logic [7:0] pe,
                                          output logic [35:0] a, output logic [35:0] q);
        a = {raw0, 3'd5, 4'hF, 1'b0, cf_rport, 1'b0, cf_manual, 8'd0, 1'b1, 1'b0,
             pe[0], pe[1], pe[2], pe[3]};
        q = {raw1, 23'd0, pe[4], pe[5], pe[6], pe[7]};
    endfunction

    function automatic res_t apply_request(req_t r);
        res_t        o;
        int          hit;
        bit          owned;
        logic [35:0] ba;
        logic [35:0] bq;
        o = '0;
        hit = -1;
        owned = 1'b0;
        case (r.mode)
            MODE_SET_MASK:
            begin
                for (int s = 0; s < MASK_SETS; s++)
                begin
                    if (set_live(s))
                    begin
                        if (sc_assign_port[s] == r.target_port)
                            hit = s;
                        if (sc_assign_port[s] == cf_rport)
                            owned = 1'b1;
                    end
                end
                if (!owned)
                    o.status = STATUS_NO_MASK;
                else if (hit >= 0)
                    sc_exec_mask[hit] = {r.word_a[35:20], r.word_q[35:20]};
            end
            MODE_GET_MASK:
            begin
                for (int s = 0; s < MASK_SETS; s++)
                    if (set_live(s) && sc_assign_port[s] == r.target_port)
                        hit = s;
                if (hit >= 0)
                begin
                    o.result_a = {sc_exec_mask[hit][31:16], 16'd0, sc_port_enable[0],
                                  sc_port_enable[1], sc_port_enable[2], sc_port_enable[3]};
                    o.result_q = {sc_exec_mask[hit][15:0], 16'd0, sc_port_enable[4],
                                  sc_port_enable[5], sc_port_enable[6], sc_port_enable[7]};
                end
            end
            MODE_MODE_REG:
                o.result_q = 36'd2 << 18;
            MODE_READ_SWITCH:
            begin
                switch_layout(assign_raw(0), assign_raw(1), sc_port_enable, ba, bq);
                o.result_a = ba;
                o.result_q = bq;
            end
            MODE_WRITE_SWITCH:
            begin
                load_assign(0, r.word_a[35:27]);
                sc_port_enable[3:0] = {r.word_a[0], r.word_a[1], r.word_a[2], r.word_a[3]};
                load_assign(1, r.word_q[35:27]);
                sc_port_enable[7:4] = {r.word_q[0], r.word_q[1], r.word_q[2], r.word_q[3]};
                switch_layout(assign_raw(0), assign_raw(1), sc_port_enable, ba, bq);
                if (ba != r.word_a || bq != r.word_q)
                    o.status = STATUS_MISMATCH;
                o.result_a = r.word_a;
                o.result_q = r.word_q;
            end
            MODE_RAISE:
            begin
                for (int s = 0; s < MASK_SETS; s++)
                begin
                    if (set_live(s) && sc_exec_mask[s][r.interrupt_number] &&
                        cf_cpu_map[sc_assign_port[s]])
                    begin
                        sc_pending[r.interrupt_number] = 1'b1;
                        o.interrupt_delivered = 1'b1;
                    end
                end
            end
            default:
                ;
        endcase
        o.pending_vector = sc_pending;
        return o;
    endfunction

    function automatic logic [8:0] pick_assign(bit own_port);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 9'($urandom) | 9'd1;
        if (k == 1)
            return 9'd0;
        if (k == 2)
            return 9'($urandom);
        if (own_port && k < 7)
            return 9'h100 >> cf_rport;
        return 9'h100 >> $urandom_range(0, 7);
    endfunction

    // mostly well-formed switch writes and requests aimed at assigned ports
    function automatic req_t make_request();
        req_t        r;
        int          k;
        int          s;
        logic [35:0] wa;
        logic [35:0] wq;
        r.mode = MODE_GET_MASK;
        r.target_port = 3'($urandom_range(0, 7));
        r.word_a = rand36();
        r.word_q = rand36();
        r.interrupt_number = 5'($urandom_range(0, 31));
        s = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0)
            r.target_port = sc_assign_port[s];
        k = $urandom_range(0, 19);
        if (k <= 5)
        begin
            switch_layout(pick_assign(1'b1), pick_assign(1'b0), 8'($urandom), wa, wq);
            if ($urandom_range(0, 5) == 0)
                wa ^= 36'd1 << $urandom_range(0, 35);
            if ($urandom_range(0, 5) == 0)
                wq ^= 36'd1 << $urandom_range(0, 35);
            r.mode = MODE_WRITE_SWITCH;
            r.word_a = wa;
            r.word_q = wq;
        end
        else if (k <= 10)
            r.mode = MODE_SET_MASK;
        else if (k <= 16)
            r.mode = (k <= 13) ? MODE_GET_MASK : MODE_RAISE;
        else if (k == 17)
            r.mode = MODE_READ_SWITCH;
        else if (k == 18)
            r.mode = MODE_MODE_REG;
        else
            r.mode = 3'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic void add_req(logic [2:0] m, logic [2:0] tp, logic [35:0] wa,
                                    logic [35:0] wq, logic [4:0] num);
        stim_row_t row;
        row = '{is_cfg: 1'b0, cfg_reg: CFG_RECEIVING_PORT, cfg_val: 8'd0,
                req: '0, typed: 1'b0, want: '0};
        row.req = {m, tp, wa, wq, num};
        directed_rows.push_back(row);
    endfunction

    // typed rows come before any interrupt is delivered, so pending is zero
    function automatic void add_known(logic [2:0] m, logic [2:0] tp, logic [35:0] wa,
                                      logic [35:0] wq, logic [4:0] num, logic [35:0] ra,
                                      logic [35:0] rq, status_t st);
        add_req(m, tp, wa, wq, num);
        directed_rows[directed_rows.size()-1].typed = 1'b1;
        directed_rows[directed_rows.size()-1].want = {ra, rq, st, 1'b0, 32'd0};
    endfunction

    function automatic void add_cfg(cfg_index_t idx, logic [7:0] val);
        stim_row_t row;
        row = '{is_cfg: 1'b1, cfg_reg: idx, cfg_val: val, req: '0, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [35:0] want, logic [35:0] got);
        if (got !== want)
        begin
            if (mismatch_count < 10)
                $display("%t %s: expected %h, got %h", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_request(req_t r, bit typed, res_t want);
        int   gap = 0;
        int   k;
        res_t predicted;
        if (!quiet)
        begin
            k = $urandom_range(0, 9);
            if (k == 9)
                gap = $urandom_range(6, 20);
            else if (k >= 6)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        mode             <= r.mode;
        target_port      <= r.target_port;
        word_a           <= r.word_a;
        word_q           <= r.word_q;
        interrupt_number <= r.interrupt_number;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_request(r);
        owed_replies.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_RECEIVING_PORT: cf_rport   = val[2:0];
            CFG_MANUAL_MODE:    cf_manual  = val[0];
            CFG_CPU_PORT_MAP:   cf_cpu_map = val;
            CFG_SETS_PRESENT:   cf_present = val[1:0];
            default:            ;
        endcase
    endtask

    // result side back-pressure: bursts, mostly short
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= !quiet && ($urandom_range(0, 3) == 0);
            stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_replies.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%t result transfer with nothing outstanding", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = owed_replies.pop_front();
                check_field("result_a", want.result_a, result_a);
                check_field("result_q", want.result_q, result_q);
                check_field("status", 36'(want.status), 36'(status));
                check_field("interrupt_delivered", 36'(want.interrupt_delivered),
                            36'(interrupt_delivered));
                check_field("pending_vector", 36'(want.pending_vector),
                            36'(pending_vector));
            end
        end
    end

    initial
    begin : stimulus
        res_t none;
        int   sent;
        int   phase_len;
        int   k;
        none = '0;

        add_known(MODE_MODE_REG, 3'd0, 36'd0, 36'd0, 5'd0, 36'd0, 36'h000080000, STATUS_OK);
        add_known(MODE_READ_SWITCH, 3'd0, 36'd0, 36'd0, 5'd0,
                  36'h00DF04020, 36'h008000000, STATUS_OK);
        add_known(MODE_SET_MASK, 3'd0, ALL36, ALL36, 5'd0, 36'd0, 36'd0, STATUS_NO_MASK);
        add_known(MODE_GET_MASK, 3'd7, 36'd0, 36'd0, 5'd0, 36'd0, 36'd0, STATUS_OK);
        add_known(MODE_RAISE, 3'd0, 36'd0, 36'd0, 5'd31, 36'd0, 36'd0, STATUS_OK);
        add_known(MODE_SPARE_6, 3'd7, ALL36, ALL36, 5'd31, 36'd0, 36'd0, STATUS_OK);
        add_known(MODE_SPARE_7, 3'd7, ALL36, ALL36, 5'd31, 36'd0, 36'd0, STATUS_OK);
        add_known(MODE_WRITE_SWITCH, 3'd0, ALL36, ALL36, 5'd0, ALL36, ALL36, STATUS_MISMATCH);
        add_req(MODE_READ_SWITCH, 3'd0, 36'd0, 36'd0, 5'd0);
        add_known(MODE_WRITE_SWITCH, 3'd0, 36'd0, 36'd0, 5'd0, 36'd0, 36'd0, STATUS_MISMATCH);
        // unassigned bit with a port bit; several port bits, highest wins
        add_req(MODE_WRITE_SWITCH, 3'd0, {9'h101, 27'd0}, {9'h1FE, 27'd5}, 5'd0);
        add_req(MODE_GET_MASK, 3'd7, 36'd0, 36'd0, 5'd0);
        add_req(MODE_READ_SWITCH, 3'd0, 36'd0, 36'd0, 5'd0);
        // clean write: set A on port 0, set B on port 3
        add_req(MODE_WRITE_SWITCH, 3'd0,
                {9'h100, 3'd5, 4'hF, 4'h0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 4'hA},
                {9'h020, 23'd0, 4'h5}, 5'd0);
        add_cfg(CFG_CPU_PORT_MAP, 8'hFF);
        add_req(MODE_SET_MASK, 3'd0, ALL36, ALL36, 5'd0);
        add_req(MODE_SET_MASK, 3'd3, {16'hAAAA, 20'hFFFFF}, {16'h5555, 20'd0}, 5'd0);
        add_req(MODE_SET_MASK, 3'd5, 36'h123456789, 36'h987654321, 5'd0);
        add_req(MODE_GET_MASK, 3'd0, 36'd0, 36'd0, 5'd0);
        add_req(MODE_GET_MASK, 3'd3, 36'd0, 36'd0, 5'd0);
        add_req(MODE_GET_MASK, 3'd5, 36'd0, 36'd0, 5'd0);
        add_req(MODE_RAISE, 3'd0, 36'd0, 36'd0, 5'd0);
        add_req(MODE_RAISE, 3'd0, 36'd0, 36'd0, 5'd31);
        add_req(MODE_RAISE, 3'd0, 36'd0, 36'd0, 5'd16);
        add_cfg(CFG_SETS_PRESENT, 8'd0);
        add_req(MODE_SET_MASK, 3'd0, ALL36, 36'd0, 5'd0);
        add_req(MODE_RAISE, 3'd0, 36'd0, 36'd0, 5'd1);
        add_cfg(CFG_RECEIVING_PORT, 8'd7);
        add_cfg(CFG_MANUAL_MODE, 8'd0);
        add_cfg(CFG_CPU_PORT_MAP, 8'd0);
        add_cfg(CFG_SETS_PRESENT, 8'd3);
        add_req(MODE_SET_MASK, 3'd3, ALL36, ALL36, 5'd0);
        add_req(MODE_READ_SWITCH, 3'd0, 36'd0, 36'd0, 5'd0);
        add_req(MODE_RAISE, 3'd0, 36'd0, 36'd0, 5'd5);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_drained();
                cfg_write(directed_rows[i].cfg_reg, directed_rows[i].cfg_val);
            end
            else
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            k = $urandom_range(0, 2);
            cfg_write(CFG_RECEIVING_PORT, (k == 0) ? 8'd0 : (k == 1) ? 8'd7
                                                                    : 8'($urandom_range(0, 7)));
            cfg_write(CFG_MANUAL_MODE, 8'($urandom_range(0, 1)));
            k = $urandom_range(0, 5);
            cfg_write(CFG_CPU_PORT_MAP, (k == 0) ? 8'd0 : (k == 1) ? 8'hFF : 8'($urandom));
            cfg_write(CFG_SETS_PRESENT, ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                                                    : 8'd3);
            quiet = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 120);
            repeat (phase_len)
            begin
                send_request(make_request(), 1'b0, none);
                sent++;
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0 && owed_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
